// ===== rtl/core/branch_exception_system_decoder_defines.svh =====
// Assertion macros for the branch/exception/system decoder.
`ifndef BRANCH_EXCEPTION_SYSTEM_DECODER_DEFINES_SVH
`define BRANCH_EXCEPTION_SYSTEM_DECODER_DEFINES_SVH
`ifndef SYNTH
`define BESD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BESD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BESD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BESD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/besd_pkg.sv =====
// ----------------------------------------------------------------------------
// besd_pkg
// Types, codes and tables shared by the decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package besd_pkg;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [63:0] pc;
  } besd_in_t;

  typedef struct packed {
    logic [5:0]  mnemonic;
    logic [5:0]  sub_op;
    logic [3:0]  cond;
    logic [15:0] immediate;
    logic [63:0] target;
    logic [4:0]  rt;
    logic        reg_shown;
    logic [2:0]  sys_op1;
    logic [3:0]  sys_crn;
    logic [3:0]  sys_crm;
    logic [2:0]  sys_op2;
  } besd_out_t;

  // instruction class found by the front end
  typedef enum logic [2:0] {
    CLS_UNDEF, CLS_BCOND, CLS_EXC, CLS_HINT, CLS_BARRIER, CLS_PSTATE, CLS_SYS
  } besd_cls_e;

  // classified beat passed through the queue
  typedef struct packed {
    besd_cls_e   cls;
    logic [31:0] instr_word;
    logic [63:0] pc;
  } besd_cmd_t;

  localparam logic [5:0] MN_UNDEF   = 6'd0;
  localparam logic [5:0] MN_UNKNOWN = 6'd1;
  localparam logic [5:0] MN_BCOND   = 6'd2;
  localparam logic [5:0] MN_HINT    = 6'd34;
  localparam logic [5:0] MN_CLREX   = 6'd35;
  localparam logic [5:0] MN_DSB     = 6'd36;
  localparam logic [5:0] MN_DMB     = 6'd37;
  localparam logic [5:0] MN_ISB     = 6'd38;
  localparam logic [5:0] MN_SSBB    = 6'd39;
  localparam logic [5:0] MN_PSSBB   = 6'd40;
  localparam logic [5:0] MN_CFINV   = 6'd41;
  localparam logic [5:0] MN_MSR     = 6'd42;
  localparam logic [5:0] MN_AT      = 6'd43;
  localparam logic [5:0] MN_DC      = 6'd44;
  localparam logic [5:0] MN_IC      = 6'd45;
  localparam logic [5:0] MN_TLBI    = 6'd46;
  localparam logic [5:0] MN_SYS     = 6'd47;
  localparam logic [5:0] MN_SYSL    = 6'd48;

  localparam logic [5:0]  SUB_PLAIN   = 6'd63;
  localparam logic [13:0] GRP_HINT    = 14'h1032;
  localparam logic [13:0] GRP_BARRIER = 14'h1033;
  localparam logic [4:0]  RT_ZR       = 5'h1f;

  localparam int unsigned SYSOP_N = 55;

  localparam logic [13:0] SYSOP_KEYS [SYSOP_N] = '{
    14'h3c0, 14'h23c0, 14'h33c0, 14'h3c1, 14'h23c1, 14'h33c1, 14'h3c2, 14'h3c3,
    14'h23c4, 14'h23c5, 14'h23c6, 14'h23c7,
    14'h1ba1, 14'h3b1, 14'h3b2, 14'h1bd1, 14'h3d2, 14'h1bd9, 14'h1bf1, 14'h3f2,
    14'h388, 14'h3a8, 14'h1ba9,
    14'h2401, 14'h2405, 14'h418, 14'h2418, 14'h3418, 14'h419, 14'h2419, 14'h3419,
    14'h41a, 14'h41b, 14'h241c, 14'h41d, 14'h241d, 14'h341d, 14'h241e, 14'h41f,
    14'h2421, 14'h2425, 14'h438, 14'h2438, 14'h3438, 14'h439, 14'h2439, 14'h3439,
    14'h43a, 14'h43b, 14'h243c, 14'h43d, 14'h243d, 14'h343d, 14'h243e, 14'h43f
  };

  localparam logic [5:0] HINT_CODES [32] = '{
    6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd34, 6'd17,
    6'd18, 6'd34, 6'd19, 6'd34, 6'd20, 6'd34, 6'd21, 6'd34,
    6'd22, 6'd23, 6'd24, 6'd34, 6'd25, 6'd34, 6'd34, 6'd34,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33
  };

  // table lookup: compare against every key in parallel
  function automatic logic [5:0] find_sysop(input logic [13:0] key);
    logic [5:0] idx;
    idx = SUB_PLAIN;
    for (int i = SYSOP_N - 1; i >= 0; i--) begin
      if (SYSOP_KEYS[i] == key) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/besd_front.sv =====
// ----------------------------------------------------------------------------
// besd_front
// Accepts instruction beats and tags each with its instruction class.
// ----------------------------------------------------------------------------
module besd_front (
  input  besd_pkg::besd_in_t  in_data_i,
  output besd_pkg::besd_cmd_t cmd_o
);
  import besd_pkg::*;

  logic [2:0]  op0;
  logic [13:0] grp;

  assign op0 = in_data_i.instr_word[31:29];
  assign grp = in_data_i.instr_word[25:12];

  always_comb begin
    cmd_o.instr_word = in_data_i.instr_word;
    cmd_o.pc         = in_data_i.pc;
    cmd_o.cls        = CLS_UNDEF;
    if (op0 == 3'd2 && grp[13] == 1'b0) begin
      cmd_o.cls = CLS_BCOND;
    end else if (op0 == 3'd6 && grp[13:12] == 2'b00) begin
      cmd_o.cls = CLS_EXC;
    end else if (op0 == 3'd6 && grp == GRP_HINT && in_data_i.instr_word[4:0] == RT_ZR) begin
      cmd_o.cls = CLS_HINT;
    end else if (op0 == 3'd6 && grp == GRP_BARRIER) begin
      cmd_o.cls = CLS_BARRIER;
    end else if (op0 == 3'd6 && grp[3:0] == 4'd4 && grp[13:7] == 7'h20) begin
      cmd_o.cls = CLS_PSTATE;
    end else if (op0 == 3'd6 && grp[13:10] == 4'd4 && grp[7]) begin
      cmd_o.cls = CLS_SYS;
    end
  end

endmodule

// ===== rtl/core/besd_queue.sv =====
// ----------------------------------------------------------------------------
// besd_queue
// Two-entry queue between front and back end; full throughput, stall is
// registered so the front never sees a combinational path from the back.
// ----------------------------------------------------------------------------
module besd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_stall_o,
  input  besd_pkg::besd_cmd_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_stall_i,
  output besd_pkg::besd_cmd_t rd_data_o
);
  import besd_pkg::*;

  besd_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/besd_back.sv =====
// ----------------------------------------------------------------------------
// besd_back
// Decodes a classified beat into the result fields; registered output.
// ----------------------------------------------------------------------------
module besd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_stall_o,
  input  besd_pkg::besd_cmd_t cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output besd_pkg::besd_out_t out_data_o
);
  import besd_pkg::*;

  logic        valid_q;
  besd_out_t   res_q, res_d;
  logic [31:0] w;
  logic [4:0]  rtf;
  logic [2:0]  op1, op2;
  logic [3:0]  crn, crm;
  logic        sysf;
  logic [63:0] off;
  logic [5:0]  sub;

  assign w   = cmd_i.instr_word;
  assign rtf = w[4:0];
  assign op2 = w[7:5];
  assign crm = w[11:8];
  assign crn = w[15:12];
  assign op1 = w[18:16];
  assign off = {{43{w[23]}}, w[23:5], 2'b00};
  assign sub = find_sysop({op1, crn, crm, op2});

  assign cmd_stall_o = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    res_d = '0;
    sysf  = 1'b0;
    case (cmd_i.cls)
      CLS_BCOND: begin
        if (!w[4] && !w[24]) begin
          res_d.mnemonic = MN_BCOND;
          res_d.cond     = w[3:0];
          res_d.target   = cmd_i.pc + off;
        end
      end
      CLS_EXC: begin
        if (w[23:21] == 3'd0 && w[4:2] == 3'd0 && w[1:0] != 2'd0)
          res_d.mnemonic = 6'd2 + {4'd0, w[1:0]};
        else if ((w[23:21] == 3'd1 || w[23:21] == 3'd2) && w[4:0] == 5'd0)
          res_d.mnemonic = 6'd5 + {3'd0, w[23:21]};
        else if (w[23:21] == 3'd5 && w[4:2] == 3'd0 && w[1:0] != 2'd0)
          res_d.mnemonic = 6'd7 + {4'd0, w[1:0]};
        if (res_d.mnemonic != MN_UNDEF) res_d.immediate = w[20:5];
      end
      CLS_HINT: begin
        res_d.mnemonic  = (crm < 4'd4) ? HINT_CODES[{crm[1:0], op2}] : MN_HINT;
        res_d.immediate = {9'd0, crm, op2};
        sysf = 1'b1;
      end
      CLS_BARRIER: begin
        if (rtf == RT_ZR) begin
          case (op2)
            3'd2: res_d.mnemonic = MN_CLREX;
            3'd5: res_d.mnemonic = MN_DMB;
            3'd6: res_d.mnemonic = MN_ISB;
            3'd4: res_d.mnemonic = (crm == 4'd0) ? MN_SSBB :
                                   (crm == 4'd4) ? MN_PSSBB : MN_DSB;
            default: res_d.mnemonic = MN_UNKNOWN;
          endcase
          if (res_d.mnemonic != MN_UNKNOWN) begin
            res_d.immediate = {12'd0, crm};
            sysf = 1'b1;
          end
        end
      end
      CLS_PSTATE: begin
        if (rtf == RT_ZR) begin
          if (op1 == 3'd0 && op2 == 3'd0) res_d.mnemonic = MN_CFINV;
          else if (op1 == 3'd0)
            res_d.mnemonic = (op2 inside {[3'd3:3'd5]}) ? MN_MSR : MN_UNDEF;
          else
            res_d.mnemonic = (op2 == 3'd2 || op2 >= 3'd6) ? MN_MSR : MN_UNDEF;
          if (res_d.mnemonic != MN_UNDEF) begin
            res_d.immediate = {12'd0, crm};
            sysf = 1'b1;
          end
        end
      end
      CLS_SYS: begin
        sysf = 1'b1;
        res_d.sub_op    = SUB_PLAIN;
        res_d.reg_shown = 1'b1;
        if (w[21]) begin
          res_d.mnemonic = MN_SYSL;
        end else begin
          res_d.sub_op = sub;
          if (sub < 6'd12) res_d.mnemonic = MN_AT;
          else if (sub < 6'd20) res_d.mnemonic = MN_DC;
          else if (sub < 6'd23) begin
            res_d.mnemonic  = MN_IC;
            res_d.reg_shown = (rtf != RT_ZR);
          end else if (sub < 6'd55) begin
            res_d.mnemonic  = MN_TLBI;
            res_d.reg_shown = (rtf != RT_ZR);
          end else res_d.mnemonic = MN_SYS;
        end
        if (res_d.reg_shown) res_d.rt = rtf;
      end
      default: ;
    endcase
    if (sysf) begin
      res_d.sys_op1 = op1;
      res_d.sys_crn = crn;
      res_d.sys_crm = crm;
      res_d.sys_op2 = op2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && !cmd_stall_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!cmd_stall_o) begin
      valid_q <= cmd_valid_i;
    end
  end

endmodule

// ===== rtl/core/branch_exception_system_decoder.sv =====
// ----------------------------------------------------------------------------
// branch_exception_system_decoder
// Branch, exception and system group decoder for 32-bit instruction words.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry {instr_word, pc}. A beat is
// taken at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry the decoded result, one
// result per input beat, in order.
// Accepted input is registered in the front/back queue, then in the back end
// output register, before the result is shown.
// Throughput: one beat per cycle while out_stall_i is low; no loop limits
// the rate, as the front end is combinational and the back end registered.
// Reset: the queue empties and the output valid drops; no other state.
// Receiver stall: the result holds; the two-entry queue keeps absorbing
// input until it fills, then in_stall_o rises (registered from queue count).
// ----------------------------------------------------------------------------
`include "branch_exception_system_decoder_defines.svh"

module branch_exception_system_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  besd_pkg::besd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output besd_pkg::besd_out_t out_data_o
);
  import besd_pkg::*;

  besd_cmd_t front_cmd, q_cmd;
  logic      q_valid, q_stall;

  besd_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd)
  );

  besd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_stall_o (in_stall_o),
    .wr_data_i  (front_cmd),
    .rd_valid_o (q_valid),
    .rd_stall_i (q_stall),
    .rd_data_o  (q_cmd)
  );

  besd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_stall_o (q_stall),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `BESD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `BESD_ASSERT(a_undef_clean, clk_i, rst_ni, out_valid_o && out_data_o.mnemonic <= MN_UNKNOWN |-> out_data_o.target == 64'd0 && out_data_o.reg_shown == 1'b0, "undefined result carries fields")
  `BESD_ASSERT(a_flow, clk_i, rst_ni, in_valid_i && !in_stall_o |=> q_valid, "accepted beat not queued")
  `BESD_ASSERT_RST(a_reset, clk_i, !rst_ni |=> !out_valid_o, "valid during reset")

endmodule
